// ===== sv/htw_pkg.sv =====
package htw_pkg;

	localparam int IDX_W           = 9;
	localparam int SYM_W           = 8;
	localparam int BYTE_W          = 8;
	localparam int VB_W            = 4;
	localparam int MAX_NODES_DEF   = 512;
	localparam int SYMBOL_BITS_DEF = 8;

	localparam logic       KIND_LOAD   = 1'b0;
	localparam logic       KIND_DECODE = 1'b1;
	localparam logic [VB_W-1:0] BITS_PER_BYTE = VB_W'(BYTE_W);

endpackage

// ===== sv/htw_item_if.sv =====
interface htw_item_if
	import htw_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [IDX_W-1:0]  node_index;
	logic [IDX_W-1:0]  left_child;
	logic [IDX_W-1:0]  right_child;
	logic              is_leaf;
	logic [SYM_W-1:0]  leaf_symbol;
	logic [BYTE_W-1:0] data_byte;
	logic [VB_W-1:0]   valid_bits;
	logic              end_of_stream;

	modport source (
		output valid, kind, node_index, left_child, right_child, is_leaf, leaf_symbol,
		       data_byte, valid_bits, end_of_stream,
		input  ready
	);
	modport sink (
		input  valid, kind, node_index, left_child, right_child, is_leaf, leaf_symbol,
		       data_byte, valid_bits, end_of_stream,
		output ready
	);
endinterface

// ===== sv/htw_result_if.sv =====
interface htw_result_if
	import htw_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             last_of_byte;

	modport source (output valid, symbol, last_of_byte, input ready);
	modport sink (input valid, symbol, last_of_byte, output ready);
endinterface

// ===== sv/htw_cfg_if.sv =====
interface htw_cfg_if
	import htw_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] root_node;

	modport source (output valid, root_node, input ready);
	modport sink (input valid, root_node, output ready);
endinterface

// ===== sv/htw_ram.sv =====
module htw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/htw_walk.sv =====
module htw_walk
	import htw_pkg::*;
#(
	parameter int MAX_NODES   = MAX_NODES_DEF,
	parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
	localparam int EW = 2 * IDX_W + 1 + SYMBOL_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	htw_item_if.sink      item,
	htw_result_if.source  result,
	htw_cfg_if.sink       cfg,
	output logic          ram_we,
	output logic [AW-1:0] ram_waddr,
	output logic [EW-1:0] ram_wdata,
	output logic          ram_re,
	output logic [AW-1:0] ram_raddr,
	input  logic [EW-1:0] ram_rdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FETCH = 3'd1;
	localparam logic [2:0] S_STEP  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	function automatic logic in_range(input logic [IDX_W-1:0] idx);
		return 32'(idx) < MAX_NODES;
	endfunction

	logic [2:0]             state_q;
	logic [IDX_W-1:0]       root_q;
	logic [IDX_W-1:0]       cur_q;
	logic [IDX_W-1:0]       nxt_q;
	logic [BYTE_W-1:0]      byte_q;
	logic [VB_W-1:0]        rem_q;
	logic                   eos_q;
	logic                   oor_q;
	logic                   pend_v_q;
	logic [SYMBOL_BITS-1:0] pend_sym_q;
	logic                   out_v_q;
	logic [SYM_W-1:0]       out_sym_q;
	logic                   out_last_q;

	logic [IDX_W-1:0]       rd_left;
	logic [IDX_W-1:0]       rd_right;
	logic                   rd_leaf;
	logic [SYMBOL_BITS-1:0] rd_sym;
	logic                   bit_now;
	logic [IDX_W-1:0]       child;
	logic [IDX_W-1:0]       raddr_idx;
	logic                   more;
	logic                   out_free;
	logic                   accept;
	logic [VB_W-1:0]        nbits;
	logic                   push_mid;
	logic                   push_last;

	assign rd_left  = oor_q ? '0 : ram_rdata[EW-1 -: IDX_W];
	assign rd_right = oor_q ? '0 : ram_rdata[EW-1-IDX_W -: IDX_W];
	assign rd_leaf  = ~oor_q & ram_rdata[SYMBOL_BITS];
	assign rd_sym   = oor_q ? '0 : ram_rdata[SYMBOL_BITS-1:0];

	assign bit_now   = (state_q == S_STEP) ? byte_q[BYTE_W-1] : byte_q[BYTE_W-2];
	assign child     = bit_now ? rd_right : rd_left;
	assign more      = rem_q > VB_W'(1);
	assign out_free  = ~out_v_q | result.ready;
	assign raddr_idx = (state_q == S_FETCH) ? cur_q : child;
	assign ram_raddr = AW'(raddr_idx);
	assign ram_re    = (state_q == S_FETCH) || (state_q == S_STEP) ||
	                   ((state_q == S_CHECK) && !rd_leaf && more);

	assign item.ready = (state_q == S_IDLE) && !cfg.valid;
	assign cfg.ready  = (state_q == S_IDLE);
	assign accept     = item.valid & item.ready;
	assign nbits      = (item.valid_bits > BITS_PER_BYTE) ? BITS_PER_BYTE : item.valid_bits;

	assign ram_we    = accept && (item.kind == KIND_LOAD) && in_range(item.node_index);
	assign ram_waddr = AW'(item.node_index);
	assign ram_wdata = {item.left_child, item.right_child, item.is_leaf,
	                    SYMBOL_BITS'(item.leaf_symbol)};

	assign push_mid  = (state_q == S_CHECK) && rd_leaf && pend_v_q && out_free;
	assign push_last = (state_q == S_DONE) && pend_v_q && out_free;

	assign result.valid        = out_v_q;
	assign result.symbol       = out_sym_q;
	assign result.last_of_byte = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			root_q   <= '0;
			cur_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (push_mid || push_last) begin
				out_v_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg.valid) begin
						root_q <= cfg.root_node;
						cur_q  <= cfg.root_node;
					end else if (accept && item.kind == KIND_DECODE) begin
						if (nbits != '0) begin
							state_q <= S_FETCH;
						end else if (item.end_of_stream) begin
							cur_q <= root_q;
						end
					end
				end
				S_FETCH: state_q <= S_STEP;
				S_STEP:  state_q <= S_CHECK;
				S_CHECK: begin
					if (!rd_leaf) begin
						cur_q <= nxt_q;
						if (!more) begin
							state_q <= S_DONE;
						end
					end else if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b1;
						cur_q    <= root_q;
						state_q  <= more ? S_FETCH : S_DONE;
					end
				end
				S_DONE: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b0;
						if (eos_q) begin
							cur_q <= root_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= item.data_byte;
			rem_q  <= nbits;
			eos_q  <= item.end_of_stream;
		end
		if (ram_re) begin
			oor_q <= ~in_range(raddr_idx);
		end
		if (state_q == S_STEP || ((state_q == S_CHECK) && !rd_leaf && more)) begin
			nxt_q <= child;
		end
		if ((state_q == S_CHECK) && (!rd_leaf || !pend_v_q || out_free)) begin
			byte_q <= byte_q << 1;
			rem_q  <= rem_q - VB_W'(1);
		end
		if ((state_q == S_CHECK) && rd_leaf && (!pend_v_q || out_free)) begin
			pend_sym_q <= rd_sym;
		end
		if (push_mid || push_last) begin
			out_sym_q  <= SYM_W'(pend_sym_q);
			out_last_q <= push_last;
		end
	end

endmodule

// ===== sv/huffman_tree_walk_decoder.sv =====
// Prefix-tree walk decoder.
// item channel: kind = load writes one node of the table in the cycle it is
//   taken; kind = decode brings one byte, MSB first, valid_bits of it used
//   (values above 8 act as 8), end_of_stream returns the walk to the root.
// result channel: one word per decoded symbol, last_of_byte on the final
//   symbol of each byte. A symbol is held back one step so that flag is known.
// cfg channel: writes root_node and restarts the walk there; ready between decodes.
// Timing: a load, or a decode with no bits, is taken without a walk. A decode then holds
//   item.ready low while it reads the root entry, then the node for each bit,
//   and the root entry again after each bit that lands on a leaf but is not
//   the final bit. The single registered-read node RAM sets this pace; one
//   lookup per coded bit.
// item.ready is high only while no decode is in progress and no cfg word waits.
// A stalled receiver holds the walk at the next leaf until its word drains.
// Reset: root and walk position go to 0, no word pending; node table
//   contents are undefined until loaded.
module huffman_tree_walk_decoder
	import htw_pkg::*;
#(
	parameter int MAX_NODES   = MAX_NODES_DEF,
	parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	htw_item_if.sink     item,
	htw_result_if.source result,
	htw_cfg_if.sink      cfg
);

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EW = 2 * IDX_W + 1 + SYMBOL_BITS;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	htw_walk #(
		.MAX_NODES  (MAX_NODES),
		.SYMBOL_BITS(SYMBOL_BITS)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.result   (result),
		.cfg      (cfg),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	htw_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_NODES)
	) u_nodes (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule
